### rtl/svrn_pkg.sv
// svrn_pkg: shared widths, constants and control word for the radius normaliser.
// No dependencies; used by every module of the block.
package svrn_pkg;

  localparam int DIMENSION_DEF = 6;
  localparam int IN_W          = 16;
  localparam int RAD_W         = 15;
  localparam int MAG_W         = IN_W + 1;
  localparam int Q_W           = IN_W + RAD_W;
  localparam int NUM_W         = 2 * Q_W + 2;
  localparam int QUO_W         = 32;
  localparam int ROOT_W        = QUO_W / 2;
  localparam int OUT_W         = 16;
  localparam int LATENCY       = 2 + QUO_W + ROOT_W + 1;

  localparam logic [RAD_W-1:0] RADIUS_RESET = 15'd14534;

  typedef struct packed {
    logic valid;
    logic zero;
  } ctl_t;

endpackage

### rtl/svrn_front.sv
// svrn_front: magnitudes, squares, radius products, sum of squares and scaled dividend.
// Two register stages. Depends on svrn_pkg.
module svrn_front #(
  parameter int DIM = svrn_pkg::DIMENSION_DEF,
  parameter int SW  = 31 + $clog2(DIM)
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  input  logic signed [svrn_pkg::IN_W-1:0]        comp [DIM],
  input  logic        [svrn_pkg::RAD_W-1:0]       radius,
  output svrn_pkg::ctl_t                          ctl,
  output logic        [SW-1:0]                    divisor,
  output logic        [SW-1:0]                    rem [DIM],
  output logic        [svrn_pkg::QUO_W-1:0]       num [DIM],
  output logic                                    sign [DIM]
);

  logic                          a_valid;
  logic [svrn_pkg::MAG_W-1:0]    a_mag  [DIM];
  logic [2*svrn_pkg::MAG_W-1:0]  a_sq   [DIM];
  logic [svrn_pkg::Q_W-1:0]      a_q    [DIM];
  logic                          a_sign [DIM];
  logic [svrn_pkg::MAG_W-1:0]    mag_c  [DIM];
  logic [SW-1:0]                 sum_c;
  logic [2*svrn_pkg::Q_W-1:0]    qq_c   [DIM];
  logic [svrn_pkg::NUM_W-1:0]    n_c    [DIM];

  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      if (comp[i][svrn_pkg::IN_W-1]) begin
        mag_c[i] = svrn_pkg::MAG_W'(-$signed({comp[i][svrn_pkg::IN_W-1], comp[i]}));
      end else begin
        mag_c[i] = {1'b0, comp[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
    for (int i = 0; i < DIM; i++) begin
      a_mag[i]  <= mag_c[i];
      a_sq[i]   <= mag_c[i] * mag_c[i];
      a_q[i]    <= svrn_pkg::Q_W'(mag_c[i]) * svrn_pkg::Q_W'(radius);
      a_sign[i] <= comp[i][svrn_pkg::IN_W-1];
    end
  end

  always_comb begin
    sum_c = '0;
    for (int i = 0; i < DIM; i++) begin
      sum_c = sum_c + SW'(a_sq[i]);
      qq_c[i] = (2*svrn_pkg::Q_W)'(a_q[i]) * (2*svrn_pkg::Q_W)'(a_q[i]);
      n_c[i] = {qq_c[i], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else begin
      ctl.valid <= a_valid;
      ctl.zero  <= (sum_c == '0);
    end
    divisor <= (sum_c == '0) ? SW'(1) : sum_c;
    for (int i = 0; i < DIM; i++) begin
      rem[i]  <= SW'(n_c[i][svrn_pkg::NUM_W-1:svrn_pkg::QUO_W]);
      num[i]  <= n_c[i][svrn_pkg::QUO_W-1:0];
      sign[i] <= a_sign[i];
    end
  end

endmodule

### rtl/svrn_div.sv
// svrn_div: restoring divider, one quotient bit per register stage for every lane.
// Depends on svrn_pkg.
module svrn_div #(
  parameter int DIM = svrn_pkg::DIMENSION_DEF,
  parameter int SW  = 31 + $clog2(DIM)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  svrn_pkg::ctl_t                    ctl_in,
  input  logic [SW-1:0]                     divisor,
  input  logic [SW-1:0]                     rem_in  [DIM],
  input  logic [svrn_pkg::QUO_W-1:0]        num_in  [DIM],
  input  logic                              sign_in [DIM],
  output svrn_pkg::ctl_t                    ctl_out,
  output logic [svrn_pkg::QUO_W-1:0]        quo     [DIM],
  output logic                              sign_out [DIM]
);

  localparam int ST = svrn_pkg::QUO_W;

  svrn_pkg::ctl_t               ctl  [ST+1];
  logic [SW-1:0]                dv   [ST+1];
  logic [SW-1:0]                rem  [ST+1][DIM];
  logic [svrn_pkg::QUO_W-1:0]   num  [ST+1][DIM];
  logic                         sgn  [ST+1][DIM];

  always_comb begin
    ctl[0] = ctl_in;
    dv[0]  = divisor;
    for (int i = 0; i < DIM; i++) begin
      rem[0][i] = rem_in[i];
      num[0][i] = num_in[i];
      sgn[0][i] = sign_in[i];
    end
  end

  for (genvar s = 0; s < ST; s++) begin : g_stage
    logic [SW:0] t [DIM];
    always_comb begin
      for (int i = 0; i < DIM; i++) begin
        t[i] = {rem[s][i], num[s][i][svrn_pkg::QUO_W-1]};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[s+1] <= '0;
      end else begin
        ctl[s+1] <= ctl[s];
      end
      dv[s+1] <= dv[s];
      for (int i = 0; i < DIM; i++) begin
        sgn[s+1][i] <= sgn[s][i];
        if (t[i] >= {1'b0, dv[s]}) begin
          rem[s+1][i] <= SW'(t[i] - {1'b0, dv[s]});
          num[s+1][i] <= {num[s][i][svrn_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem[s+1][i] <= t[i][SW-1:0];
          num[s+1][i] <= {num[s][i][svrn_pkg::QUO_W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    ctl_out = ctl[ST];
    for (int i = 0; i < DIM; i++) begin
      quo[i]      = num[ST][i];
      sign_out[i] = sgn[ST][i];
    end
  end

endmodule

### rtl/svrn_sqrt.sv
// svrn_sqrt: digit-by-digit square root, one root bit per stage, then round, sign and clamp.
// Depends on svrn_pkg.
module svrn_sqrt #(
  parameter int DIM = svrn_pkg::DIMENSION_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  svrn_pkg::ctl_t                    ctl_in,
  input  logic [svrn_pkg::QUO_W-1:0]        val_in  [DIM],
  input  logic                              sign_in [DIM],
  output logic                              done,
  output logic                              zero_norm,
  output logic signed [svrn_pkg::OUT_W-1:0] res     [DIM]
);

  localparam int ST  = svrn_pkg::ROOT_W;
  localparam int RW  = svrn_pkg::ROOT_W + 2;
  localparam int TW  = RW + 2;

  svrn_pkg::ctl_t               ctl  [ST+1];
  logic [RW-1:0]                rem  [ST+1][DIM];
  logic [svrn_pkg::ROOT_W-1:0]  root [ST+1][DIM];
  logic [svrn_pkg::QUO_W-1:0]   val  [ST+1][DIM];
  logic                         sgn  [ST+1][DIM];
  logic [svrn_pkg::ROOT_W:0]    n    [DIM];
  logic [svrn_pkg::OUT_W-1:0]   r_c  [DIM];

  always_comb begin
    ctl[0] = ctl_in;
    for (int i = 0; i < DIM; i++) begin
      rem[0][i]  = '0;
      root[0][i] = '0;
      val[0][i]  = val_in[i];
      sgn[0][i]  = sign_in[i];
    end
  end

  for (genvar s = 0; s < ST; s++) begin : g_stage
    logic [TW-1:0] t     [DIM];
    logic [TW-1:0] trial [DIM];
    always_comb begin
      for (int i = 0; i < DIM; i++) begin
        t[i]     = {rem[s][i], val[s][i][svrn_pkg::QUO_W-1 -: 2]};
        trial[i] = {2'b00, root[s][i], 2'b01};
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[s+1] <= '0;
      end else begin
        ctl[s+1] <= ctl[s];
      end
      for (int i = 0; i < DIM; i++) begin
        sgn[s+1][i] <= sgn[s][i];
        val[s+1][i] <= {val[s][i][svrn_pkg::QUO_W-3:0], 2'b00};
        if (t[i] >= trial[i]) begin
          rem[s+1][i]  <= RW'(t[i] - trial[i]);
          root[s+1][i] <= {root[s][i][svrn_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem[s+1][i]  <= t[i][RW-1:0];
          root[s+1][i] <= {root[s][i][svrn_pkg::ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < DIM; i++) begin
      n[i] = ({1'b0, root[ST][i]} + 1'b1) >> 1;
      if (ctl[ST].zero) begin
        r_c[i] = '0;
      end else if (sgn[ST][i]) begin
        r_c[i] = svrn_pkg::OUT_W'(-n[i]);
      end else if (n[i] > (svrn_pkg::ROOT_W+1)'(16'h7FFF)) begin
        r_c[i] = 16'h7FFF;
      end else begin
        r_c[i] = n[i][svrn_pkg::OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl[ST].valid;
    end
    zero_norm <= ctl[ST].zero;
    for (int i = 0; i < DIM; i++) begin
      res[i] <= r_c[i];
    end
  end

endmodule

### rtl/six_vector_radius_normalize.sv
// six_vector_radius_normalize: top level, radius register and the three pipeline sections.
// Depends on svrn_pkg, svrn_front, svrn_div, svrn_sqrt.
//
//  channel   handshake               payload
//  input     start / busy            pos_x pos_y pos_z angle_theta angle_phi angle_lambda
//  config    cfg_valid / cfg_ready   cfg_data (target_radius)
//  result    done (strobe)           out_x .. out_lambda, zero_norm
//
// One vector enters every cycle; its result strobes out after the two front stages,
// one stage per quotient bit, one per root bit and the output register.
// Reset clears the valid bits and sets the radius to its default; busy stays low.
// Nothing stalls: the pipeline advances every cycle.
module six_vector_radius_normalize (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [svrn_pkg::IN_W-1:0]  pos_x,
  input  logic signed [svrn_pkg::IN_W-1:0]  pos_y,
  input  logic signed [svrn_pkg::IN_W-1:0]  pos_z,
  input  logic signed [svrn_pkg::IN_W-1:0]  angle_theta,
  input  logic signed [svrn_pkg::IN_W-1:0]  angle_phi,
  input  logic signed [svrn_pkg::IN_W-1:0]  angle_lambda,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [svrn_pkg::RAD_W-1:0]        cfg_data,
  output logic                              done,
  output logic signed [svrn_pkg::OUT_W-1:0] out_x,
  output logic signed [svrn_pkg::OUT_W-1:0] out_y,
  output logic signed [svrn_pkg::OUT_W-1:0] out_z,
  output logic signed [svrn_pkg::OUT_W-1:0] out_theta,
  output logic signed [svrn_pkg::OUT_W-1:0] out_phi,
  output logic signed [svrn_pkg::OUT_W-1:0] out_lambda,
  output logic                              zero_norm
);

  localparam int DIMENSION = svrn_pkg::DIMENSION_DEF;
  localparam int SW        = 31 + $clog2(DIMENSION);

  logic [svrn_pkg::RAD_W-1:0]        target_radius;
  logic signed [svrn_pkg::IN_W-1:0]  comp [DIMENSION];
  svrn_pkg::ctl_t                    f_ctl, d_ctl;
  logic [SW-1:0]                     f_div;
  logic [SW-1:0]                     f_rem  [DIMENSION];
  logic [svrn_pkg::QUO_W-1:0]        f_num  [DIMENSION];
  logic                              f_sign [DIMENSION];
  logic [svrn_pkg::QUO_W-1:0]        d_quo  [DIMENSION];
  logic                              d_sign [DIMENSION];
  logic signed [svrn_pkg::OUT_W-1:0] res    [DIMENSION];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_radius <= svrn_pkg::RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      target_radius <= cfg_data;
    end
  end

  always_comb begin
    for (int i = 0; i < DIMENSION; i++) begin
      comp[i] = '0;
    end
    comp[0] = pos_x;
    comp[1] = pos_y;
    comp[2] = pos_z;
    comp[3] = angle_theta;
    comp[4] = angle_phi;
    comp[5] = angle_lambda;
  end

  svrn_front #(.DIM(DIMENSION), .SW(SW)) u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy), .comp(comp), .radius(target_radius),
    .ctl(f_ctl), .divisor(f_div), .rem(f_rem), .num(f_num), .sign(f_sign)
  );

  svrn_div #(.DIM(DIMENSION), .SW(SW)) u_div (
    .clk(clk), .rst(rst), .ctl_in(f_ctl), .divisor(f_div), .rem_in(f_rem),
    .num_in(f_num), .sign_in(f_sign), .ctl_out(d_ctl), .quo(d_quo), .sign_out(d_sign)
  );

  svrn_sqrt #(.DIM(DIMENSION)) u_sqrt (
    .clk(clk), .rst(rst), .ctl_in(d_ctl), .val_in(d_quo), .sign_in(d_sign),
    .done(done), .zero_norm(zero_norm), .res(res)
  );

  assign out_x      = res[0];
  assign out_y      = res[1];
  assign out_z      = res[2];
  assign out_theta  = res[3];
  assign out_phi    = res[4];
  assign out_lambda = res[5];

endmodule

### rtl/svrn_checker.sv
// svrn_checker: port-level checks on the radius normaliser, bound to the top level.
// Depends on svrn_pkg and six_vector_radius_normalize.
module svrn_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              start,
  input logic                              busy,
  input logic                              done,
  input logic                              zero_norm,
  input logic signed [svrn_pkg::OUT_W-1:0] out_x,
  input logic signed [svrn_pkg::OUT_W-1:0] out_y,
  input logic signed [svrn_pkg::OUT_W-1:0] out_lambda
);

  a_no_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, svrn_pkg::LATENCY))
    else $error("result word without matching input word");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    done && zero_norm |-> out_x == '0 && out_y == '0 && out_lambda == '0)
    else $error("zero vector gave non-zero word");

endmodule

bind six_vector_radius_normalize svrn_checker u_svrn_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .zero_norm(zero_norm),
  .out_x(out_x), .out_y(out_y), .out_lambda(out_lambda)
);

### bench/tb_six_vector_radius_normalize.sv
// Self-checking bench for six_vector_radius_normalize: directed table then random vectors,
// each result checked against its typed table entry or a bit-exact normalisation predictor.
// Depends on svrn_pkg and the six_vector_radius_normalize RTL.
module tb_six_vector_radius_normalize;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 400000;

  typedef logic signed [svrn_pkg::IN_W-1:0] comp_t;

  typedef struct {
    logic signed [svrn_pkg::OUT_W-1:0] v [6];
    logic                              zero;
  } pose_out_t;

  typedef struct {
    logic [svrn_pkg::RAD_W-1:0] radius;
    comp_t                      v [6];
    bit                         typed;
    pose_out_t                  want;
  } row_t;

  logic clk, rst, start, busy, cfg_valid, cfg_ready, done, zero_norm;
  comp_t pos_x, pos_y, pos_z, angle_theta, angle_phi, angle_lambda;
  logic [svrn_pkg::RAD_W-1:0] cfg_data;
  logic signed [svrn_pkg::OUT_W-1:0] out_x, out_y, out_z, out_theta, out_phi, out_lambda;

  pose_out_t                  pending [$];
  row_t                       dir_rows [$];
  logic [svrn_pkg::RAD_W-1:0] radius_now;
  int                         mismatches;
  int                         cycles;
  bit                         quiet;

  six_vector_radius_normalize dut (
    .clk, .rst, .start, .busy, .pos_x, .pos_y, .pos_z, .angle_theta, .angle_phi,
    .angle_lambda, .cfg_valid, .cfg_ready, .cfg_data, .done, .out_x, .out_y, .out_z,
    .out_theta, .out_phi, .out_lambda, .zero_norm
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic longint unsigned int_sqrt(longint unsigned a);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > a) b >>= 2;
    while (b != 0) begin
      if (a >= root + b) begin
        a -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  function automatic pose_out_t normalise(comp_t v [6], logic [svrn_pkg::RAD_W-1:0] r);
    pose_out_t       o;
    longint unsigned mag [6];
    longint unsigned sum, q, m, n;
    sum = 0;
    for (int i = 0; i < 6; i++) begin
      mag[i] = v[i] < 0 ? longint'(-longint'(v[i])) : longint'(v[i]);
      sum += mag[i] * mag[i];
    end
    o.zero = (sum == 0);
    for (int i = 0; i < 6; i++) begin
      if (sum == 0) begin
        o.v[i] = '0;
      end else begin
        q = mag[i] * r;
        m = (4 * q * q) / sum;
        n = (int_sqrt(m) + 1) >> 1;
        if (v[i] < 0) begin
          if (n > 32768) n = 32768;
          o.v[i] = svrn_pkg::OUT_W'(-longint'(n));
        end else begin
          if (n > 32767) n = 32767;
          o.v[i] = svrn_pkg::OUT_W'(n);
        end
      end
    end
    return o;
  endfunction

  function automatic void add_row(int r, int a0, int a1, int a2,
                                  int a3, int a4, int a5, bit typed,
                                  int e0 = 0, int e1 = 0, int e2 = 0, int e3 = 0,
                                  int e4 = 0, int e5 = 0, bit ez = 0);
    row_t w;
    w.radius = svrn_pkg::RAD_W'(r);
    w.v = '{comp_t'(a0), comp_t'(a1), comp_t'(a2), comp_t'(a3), comp_t'(a4), comp_t'(a5)};
    w.typed = typed;
    w.want.v = '{svrn_pkg::OUT_W'(e0), svrn_pkg::OUT_W'(e1), svrn_pkg::OUT_W'(e2),
                 svrn_pkg::OUT_W'(e3), svrn_pkg::OUT_W'(e4), svrn_pkg::OUT_W'(e5)};
    w.want.zero = ez;
    dir_rows.push_back(w);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // check each word leaving the block against the oldest expectation
  always @(posedge clk) begin
    pose_out_t got, exp_w;
    if (!rst && done) begin
      got.v = '{out_x, out_y, out_z, out_theta, out_phi, out_lambda};
      got.zero = zero_norm;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word at cycle %0d", cycles);
      end else begin
        exp_w = pending.pop_front();
        if (got.v != exp_w.v || got.zero != exp_w.zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cycle %0d: exp %p got %p", cycles, exp_w, got);
        end
      end
    end
  end

  // drive one vector; returns at the edge that accepts it with start still high
  task automatic send(comp_t v [6], bit typed, pose_out_t want);
    int gap;
    gap = (!quiet && $urandom_range(99) < 20) ? $urandom_range(3, 1) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    {pos_x, pos_y, pos_z, angle_theta, angle_phi, angle_lambda} <=
      {v[0], v[1], v[2], v[3], v[4], v[5]};
    do @(posedge clk); while (busy);
    pending.push_back(typed ? want : normalise(v, radius_now));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (svrn_pkg::LATENCY) @(posedge clk);
  endtask

  task automatic set_radius(logic [svrn_pkg::RAD_W-1:0] r);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= r;
    do @(posedge clk); while (!cfg_ready);
    radius_now = r;
    cfg_valid <= 1'b0;
  endtask

  function automatic comp_t rand_comp(int kind);
    case (kind)
      0: return comp_t'($urandom());
      1: return comp_t'($urandom_range(15, 0)) - comp_t'(8);
      2: return comp_t'($signed($urandom()) >>> $urandom_range(15, 0));
      default: return $urandom_range(1) ? comp_t'(16'h7FFF) : comp_t'(16'h8000);
    endcase
  endfunction

  initial begin
    pose_out_t                  none;
    comp_t                      v [6];
    int                         kind;
    logic [svrn_pkg::RAD_W-1:0] radii [6];
    rst = 1'b1;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    {pos_x, pos_y, pos_z, angle_theta, angle_phi, angle_lambda} = '0;
    mismatches = 0;
    cycles = 0;
    quiet = 0;
    radius_now = svrn_pkg::RADIUS_RESET;
    none.v = '{6{'0}};
    none.zero = 0;

    add_row(14534, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1);
    add_row(14534, 32767, 0, 0, 0, 0, 0, 1, 14534);
    add_row(14534, 0, -32768, 0, 0, 0, 0, 1, 0, -14534);
    add_row(14534, 0, 0, 1, 0, 0, 0, 1, 0, 0, 14534);
    add_row(14534, 0, 0, 0, -1, 0, 0, 1, 0, 0, 0, -14534);
    add_row(14534, 0, 0, 0, 0, 32767, 0, 1, 0, 0, 0, 0, 14534);
    add_row(14534, 0, 0, 0, 0, 0, -32768, 1, 0, 0, 0, 0, 0, -14534);
    add_row(14534, 32767, 32767, 32767, 32767, 32767, 32767, 0);
    add_row(14534, -32768, -32768, -32768, -32768, -32768, -32768, 0);
    add_row(14534, 16'sh5555, -16'sh2AAB, 1, -1, 32767, -32768, 0);
    add_row(14534, 3, -4, 0, 0, 0, 0, 0);
    add_row(0, 32767, 0, 0, 0, 0, 0, 1);
    add_row(0, -32768, -32768, -32768, -32768, -32768, -32768, 0);
    add_row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1);
    add_row(32767, 32767, 0, 0, 0, 0, 0, 1, 32767);
    add_row(32767, 0, -32768, 0, 0, 0, 0, 1, 0, -32767);
    add_row(32767, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1);
    add_row(32767, 100, -200, 300, -400, 500, -600, 0);
    add_row(1, -1, 0, 0, 0, 0, 0, 1, -1);
    add_row(1, 20000, 20000, -20000, 1, 0, 0, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].radius != radius_now) set_radius(dir_rows[i].radius);
      send(dir_rows[i].v, dir_rows[i].typed, dir_rows[i].want);
    end

    radii = '{svrn_pkg::RADIUS_RESET, 15'h7FFF, 15'd0, 15'h2AAA, 15'h5555,
              svrn_pkg::RAD_W'($urandom())};
    for (int n = 0; n < 1700; n++) begin
      if (n % 300 == 0) set_radius(radii[n / 300]);
      if (n == 850) drain();
      quiet = (n >= 900 && n < 1150);
      kind = $urandom_range(99);
      for (int i = 0; i < 6; i++)
        v[i] = kind < 45 ? rand_comp(0) : kind < 65 ? rand_comp(2) :
               kind < 80 ? rand_comp(1) : kind < 92 ? rand_comp($urandom_range(3)) : '0;
      if (kind >= 92 && kind < 97) v[$urandom_range(5)] = rand_comp($urandom_range(3));
      send(v, 0, none);
    end
    start <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (svrn_pkg::LATENCY + 5) @(posedge clk);
    if (mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

### six_vector_radius_normalize.f
rtl/svrn_pkg.sv
rtl/svrn_front.sv
rtl/svrn_div.sv
rtl/svrn_sqrt.sv
rtl/six_vector_radius_normalize.sv
rtl/svrn_checker.sv
bench/tb_six_vector_radius_normalize.sv
